FILE: rtl/secc_pkg.sv
// Shared types and codes for the SCAN elevator car controller.
package secc_pkg;

   // Fixed field widths of the request and response items
   localparam int OP_W          = 3;
   localparam int REQ_FLOOR_W   = 5;
   localparam int OUT_FLOOR_W   = 5;
   localparam int MODE_W        = 2;
   localparam int DIR_W         = 2;
   localparam int OUT_MAP_W     = 16;
   localparam int OUT_COUNT_W   = 5;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [DIR_W-1:0]  dir_type;

   // Operation codes
   localparam op_type OP_STEP        = 3'd0;
   localparam op_type OP_REQUEST     = 3'd1;
   localparam op_type OP_EMERG_SET   = 3'd2;
   localparam op_type OP_EMERG_CLEAR = 3'd3;
   localparam op_type OP_MAINT_ENTER = 3'd4;
   localparam op_type OP_MAINT_LEAVE = 3'd5;

   // Car modes
   localparam mode_type MODE_IDLE   = 2'd0;
   localparam mode_type MODE_MOVING = 2'd1;
   localparam mode_type MODE_EMERG  = 2'd2;
   localparam mode_type MODE_MAINT  = 2'd3;

   // Travel directions
   localparam dir_type DIR_STILL = 2'd0;
   localparam dir_type DIR_UP    = 2'd1;
   localparam dir_type DIR_DESC  = 2'd2;

endpackage

FILE: rtl/secc_req_if.sv
// Request channel: operation and requested floor.
interface secc_req_if import secc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [REQ_FLOOR_W-1:0] request_floor;

   modport source (output valid, output operation, output request_floor, input ready);
   modport sink   (input valid, input operation, input request_floor, output ready);
endinterface

FILE: rtl/secc_rsp_if.sv
// Response channel: car status after each item.
interface secc_rsp_if import secc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OUT_FLOOR_W-1:0] car_floor_now;
   logic [MODE_W-1:0]      car_mode_now;
   logic [DIR_W-1:0]       direction_now;
   logic [OUT_FLOOR_W-1:0] chosen_floor;
   logic                   served;
   logic [OUT_MAP_W-1:0]   pending_map;
   logic [OUT_COUNT_W-1:0] pending_count;

   modport source (output valid, output car_floor_now, output car_mode_now,
                   output direction_now, output chosen_floor, output served,
                   output pending_map, output pending_count, input ready);
   modport sink   (input valid, input car_floor_now, input car_mode_now,
                   input direction_now, input chosen_floor, input served,
                   input pending_map, input pending_count, output ready);
endinterface

FILE: rtl/scan_elevator_car_controller.sv
// SCAN elevator car controller top level: sequencer, floor sweep and car state.
// Step tick (car not halted): scan state, then finish state registers the result;
//   the floor sweep checks one floor per cycle through a single compare unit.
// Other items, and ticks while halted: finish state registers the result directly.
// Finish waits for a free response slot; new items are taken only back in idle.
// Synchronous active-high reset: ground floor, no requests, no direction, idle.
module scan_elevator_car_controller import secc_pkg::*; #(
   parameter int FLOOR_COUNT = 16
) (
   input  logic       clock,
   input  logic       reset,
   secc_req_if.sink   req_chan,
   secc_rsp_if.source rsp_chan
);

   localparam int FLOOR_W = $clog2(FLOOR_COUNT + 1);
   localparam int IDX_W   = $clog2(FLOOR_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // Control and car state
   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [FLOOR_COUNT-1:0] map_ff, map_in;
   logic [FLOOR_W-1:0]     count_ff, count_in;
   logic [FLOOR_W-1:0]     car_ff, car_in;
   dir_type                dir_ff, dir_in;
   mode_type               mode_ff, mode_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Latched item and sweep results
   op_type                 op_ff, op_in;
   logic [REQ_FLOOR_W-1:0] rf_ff, rf_in;
   logic [FLOOR_W-1:0]     max_le_ff, max_le_in;
   logic [FLOOR_W-1:0]     min_ge_ff, min_ge_in;

   // Response payload
   logic [FLOOR_W-1:0]     out_car_ff, out_target_ff, out_count_ff;
   logic [FLOOR_W-1:0]     out_target_in;
   mode_type               out_mode_ff;
   dir_type                out_dir_ff;
   logic                   out_served_ff, out_served_in;
   logic [FLOOR_COUNT-1:0] out_map_ff;

   logic                   accept;
   logic                   finish;
   logic                   halted;
   logic [FLOOR_W-1:0]     sweep_floor;
   logic                   sweep_pend;
   logic [FLOOR_W-1:0]     d_lo, d_hi;
   logic [FLOOR_W-1:0]     target;
   logic [FLOOR_W-1:0]     car_m1, next_car, next_car_m1;
   logic [IDX_W+4:0]       rf_m1_ext;
   logic                   rf_ok;

   // Response fields widened before trimming to the fixed widths
   logic [FLOOR_W+OUT_FLOOR_W-1:0]   car_ext, target_ext;
   logic [FLOOR_W+OUT_COUNT_W-1:0]   count_ext;
   logic [FLOOR_COUNT+OUT_MAP_W-1:0] map_ext;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign finish         = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);
   assign halted         = (mode_ff == MODE_EMERG) || (mode_ff == MODE_MAINT);

   // Shared compare unit: one floor per cycle
   assign sweep_floor = FLOOR_W'(idx_ff) + FLOOR_W'(1);
   assign sweep_pend  = map_ff[idx_ff];

   // SCAN target from the sweep: highest pending at or below, lowest at or above
   assign d_lo = car_ff - max_le_ff;
   assign d_hi = min_ge_ff - car_ff;

   always_comb begin
      case (dir_ff)
         DIR_UP:   target = (min_ge_ff != '0) ? min_ge_ff : max_le_ff;
         DIR_DESC: target = (max_le_ff != '0) ? max_le_ff : min_ge_ff;
         default: begin
            if (max_le_ff == '0) begin
               target = min_ge_ff;
            end else if (min_ge_ff == '0) begin
               target = max_le_ff;
            end else begin
               target = (d_lo <= d_hi) ? max_le_ff : min_ge_ff;
            end
         end
      endcase
   end

   assign car_m1      = car_ff - FLOOR_W'(1);
   assign next_car    = (target > car_ff) ? car_ff + FLOOR_W'(1) : car_m1;
   assign next_car_m1 = next_car - FLOOR_W'(1);
   assign rf_m1_ext   = (IDX_W + 5)'(rf_ff) - (IDX_W + 5)'(1);
   assign rf_ok       = (rf_ff != '0) && (32'(rf_ff) <= FLOOR_COUNT);

   // Sequencer and state update
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      map_in        = map_ff;
      count_in      = count_ff;
      car_in        = car_ff;
      dir_in        = dir_ff;
      mode_in       = mode_ff;
      op_in         = op_ff;
      rf_in         = rf_ff;
      max_le_in     = max_le_ff;
      min_ge_in     = min_ge_ff;
      out_target_in = '0;
      out_served_in = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_chan.operation;
               rf_in     = req_chan.request_floor;
               idx_in    = '0;
               max_le_in = '0;
               min_ge_in = '0;
               if (req_chan.operation == OP_STEP && !halted) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (sweep_pend && sweep_floor <= car_ff) begin
               max_le_in = sweep_floor;
            end
            if (sweep_pend && sweep_floor >= car_ff && min_ge_ff == '0) begin
               min_ge_in = sweep_floor;
            end
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(FLOOR_COUNT - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               case (op_ff)
                  OP_STEP: begin
                     if (!halted) begin
                        out_target_in = target;
                        mode_in       = MODE_IDLE;
                        if (target == '0) begin
                           dir_in = DIR_STILL;
                        end else if (target == car_ff) begin
                           map_in[car_m1[IDX_W-1:0]] = 1'b0;
                           count_in      = count_ff - FLOOR_W'(1);
                           out_served_in = 1'b1;
                        end else begin
                           car_in = next_car;
                           dir_in = (target > car_ff) ? DIR_UP : DIR_DESC;
                           if (map_ff[next_car_m1[IDX_W-1:0]]) begin
                              map_in[next_car_m1[IDX_W-1:0]] = 1'b0;
                              count_in      = count_ff - FLOOR_W'(1);
                              out_served_in = 1'b1;
                           end
                        end
                        if (count_in == '0) begin
                           dir_in = DIR_STILL;
                        end
                     end
                  end
                  OP_REQUEST: begin
                     if (rf_ok && !map_ff[rf_m1_ext[IDX_W-1:0]]) begin
                        map_in[rf_m1_ext[IDX_W-1:0]] = 1'b1;
                        count_in = count_ff + FLOOR_W'(1);
                     end
                  end
                  OP_EMERG_SET: mode_in = MODE_EMERG;
                  OP_EMERG_CLEAR: begin
                     if (mode_ff == MODE_EMERG) mode_in = MODE_IDLE;
                  end
                  OP_MAINT_ENTER: begin
                     if (mode_ff != MODE_EMERG) mode_in = MODE_MAINT;
                  end
                  OP_MAINT_LEAVE: begin
                     if (mode_ff == MODE_MAINT) mode_in = MODE_IDLE;
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and car state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_ff       <= '0;
         count_ff     <= '0;
         car_ff       <= FLOOR_W'(1);
         dir_ff       <= DIR_STILL;
         mode_ff      <= MODE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_ff       <= map_in;
         count_ff     <= count_in;
         car_ff       <= car_in;
         dir_ff       <= dir_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and sweep registers, response payload
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      op_ff     <= op_in;
      rf_ff     <= rf_in;
      max_le_ff <= max_le_in;
      min_ge_ff <= min_ge_in;
      if (finish) begin
         out_car_ff    <= car_in;
         out_mode_ff   <= mode_in;
         out_dir_ff    <= dir_in;
         out_target_ff <= out_target_in;
         out_served_ff <= out_served_in;
         out_map_ff    <= map_in;
         out_count_ff  <= count_in;
      end
   end

   // Response port: fit internal widths to the fixed field widths
   assign car_ext    = {{OUT_FLOOR_W{1'b0}}, out_car_ff};
   assign target_ext = {{OUT_FLOOR_W{1'b0}}, out_target_ff};
   assign count_ext  = {{OUT_COUNT_W{1'b0}}, out_count_ff};
   assign map_ext    = {{OUT_MAP_W{1'b0}}, out_map_ff};

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.car_floor_now = car_ext[OUT_FLOOR_W-1:0];
   assign rsp_chan.car_mode_now  = out_mode_ff;
   assign rsp_chan.direction_now = out_dir_ff;
   assign rsp_chan.chosen_floor  = target_ext[OUT_FLOOR_W-1:0];
   assign rsp_chan.served        = out_served_ff;
   assign rsp_chan.pending_map   = map_ext[OUT_MAP_W-1:0];
   assign rsp_chan.pending_count = count_ext[OUT_COUNT_W-1:0];

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the SCAN elevator car controller.
`timescale 1ns / 1ps

module tb_top import secc_pkg::*; ();

   localparam int FLOORS = 16;
   localparam int HOLD_OFF_AT = 300;   // response count at which the long stall starts
   localparam int HOLD_OFF_LEN = 400;
   localparam int RANDOM_ITEMS = 1500;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   // Codes the block does not use; they must leave everything as it was
   localparam op_type OP_SPARE6 = 3'd6;
   localparam op_type OP_SPARE7 = 3'd7;

   typedef struct {
      logic [OUT_FLOOR_W-1:0] floor_now;
      mode_type               mode_now;
      dir_type                dir_now;
      logic [OUT_FLOOR_W-1:0] target;
      logic                   served;
      logic [OUT_MAP_W-1:0]   pend_map;
      logic [OUT_COUNT_W-1:0] pend_count;
   } car_status_type;

   typedef struct {
      op_type                 op;
      logic [REQ_FLOOR_W-1:0] floor;
      bit                     typed;
      car_status_type         want;
   } plan_row_type;

   logic clock;
   logic reset;

   secc_req_if req_bus ();
   secc_rsp_if rsp_bus ();

   scan_elevator_car_controller #(.FLOOR_COUNT(FLOORS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Car state as the checker sees it
   logic [FLOORS-1:0] pend_floors;
   int                at_floor;
   dir_type           heading;
   mode_type          car_state;

   car_status_type status_q[$];
   plan_row_type   directed_plan[$];
   int             mismatch_count;
   int             error_count;
   int             rsp_count;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #(5_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   // Every fourth block of 64 items runs without gaps
   function automatic int draw_gap(input int n);
      if ((n / 64) % 4 == 3) return 0;
      return $urandom_range(0, 16);
   endfunction

   // SCAN choice: ahead first (current floor included), then behind; no heading means nearest
   function automatic int sweep_target();
      int f;
      int best;
      int best_dist;
      int d;
      best = 0;
      best_dist = FLOORS + 1;
      if (heading == DIR_UP) begin
         for (f = at_floor; f <= FLOORS; f++) if (pend_floors[f-1]) return f;
         for (f = at_floor - 1; f >= 1; f--) if (pend_floors[f-1]) return f;
      end else if (heading == DIR_DESC) begin
         for (f = at_floor; f >= 1; f--) if (pend_floors[f-1]) return f;
         for (f = at_floor + 1; f <= FLOORS; f++) if (pend_floors[f-1]) return f;
      end else begin
         for (f = 1; f <= FLOORS; f++) begin
            if (pend_floors[f-1]) begin
               d = (f > at_floor) ? f - at_floor : at_floor - f;
               if (d < best_dist) begin
                  best_dist = d;
                  best = f;
               end
            end
         end
      end
      return best;
   endfunction

   // Apply one item to the car state and return the status it reports
   function automatic car_status_type advance_car(input op_type op,
                                                  input logic [REQ_FLOOR_W-1:0] rf);
      car_status_type st;
      int             tgt;
      logic           hit;
      tgt = 0;
      hit = 1'b0;
      case (op)
         OP_STEP: begin
            if (car_state != MODE_EMERG && car_state != MODE_MAINT) begin
               tgt = sweep_target();
               if (tgt == 0) begin
                  car_state = MODE_IDLE;
                  heading = DIR_STILL;
               end else begin
                  if (tgt == at_floor) begin
                     pend_floors[at_floor-1] = 1'b0;
                     hit = 1'b1;
                  end else begin
                     if (tgt > at_floor) begin
                        heading = DIR_UP;
                        if (at_floor < FLOORS) at_floor++;
                     end else begin
                        heading = DIR_DESC;
                        if (at_floor > 1) at_floor--;
                     end
                     if (pend_floors[at_floor-1]) begin
                        pend_floors[at_floor-1] = 1'b0;
                        hit = 1'b1;
                     end
                  end
                  car_state = MODE_IDLE;
                  if (pend_floors == '0) heading = DIR_STILL;
               end
            end
         end
         OP_REQUEST: begin
            if (rf >= 1 && rf <= FLOORS) pend_floors[rf-1] = 1'b1;
         end
         OP_EMERG_SET: car_state = MODE_EMERG;
         OP_EMERG_CLEAR: begin
            if (car_state == MODE_EMERG) car_state = MODE_IDLE;
         end
         OP_MAINT_ENTER: begin
            if (car_state != MODE_EMERG) car_state = MODE_MAINT;
         end
         OP_MAINT_LEAVE: begin
            if (car_state == MODE_MAINT) car_state = MODE_IDLE;
         end
         default: ;
      endcase
      st.floor_now  = at_floor[OUT_FLOOR_W-1:0];
      st.mode_now   = car_state;
      st.dir_now    = heading;
      st.target     = tgt[OUT_FLOOR_W-1:0];
      st.served     = hit;
      st.pend_map   = pend_floors[OUT_MAP_W-1:0];
      st.pend_count = OUT_COUNT_W'($countones(pend_floors));
      return st;
   endfunction

   // Offer one item after a random gap; valid stays high on return
   task automatic send_item(input op_type op, input logic [REQ_FLOOR_W-1:0] rf,
                            input int n, input bit typed, input car_status_type want);
      int             gap;
      car_status_type st;
      gap = draw_gap(n);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= op;
      req_bus.request_floor <= rf;
      do @(posedge clock); while (!req_bus.ready);
      st = advance_car(op, rf);
      status_q.push_back(typed ? want : st);
   endtask

   // Response side: random stalls, one long hold-off, field-by-field check
   initial begin
      int             gap;
      car_status_type exp_st;
      bit             bad;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = (rsp_count == HOLD_OFF_AT) ? HOLD_OFF_LEN : draw_gap(rsp_count);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         rsp_count++;
         if (status_q.size() == 0) begin
            error_count++;
            if (error_count + mismatch_count <= REPORT_LIMIT)
               $display("%0t: result with no item outstanding", $realtime);
         end else begin
            exp_st = status_q.pop_front();
            bad = (rsp_bus.car_floor_now !== exp_st.floor_now)
               || (rsp_bus.car_mode_now  !== exp_st.mode_now)
               || (rsp_bus.direction_now !== exp_st.dir_now)
               || (rsp_bus.chosen_floor  !== exp_st.target)
               || (rsp_bus.served        !== exp_st.served)
               || (rsp_bus.pending_map   !== exp_st.pend_map)
               || (rsp_bus.pending_count !== exp_st.pend_count);
            if (bad) begin
               mismatch_count++;
               if (error_count + mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: item %0d mismatch (expected/actual)",
                           $realtime, rsp_count);
                  $display("  floor %0d/%0d mode %0d/%0d dir %0d/%0d target %0d/%0d",
                           exp_st.floor_now, rsp_bus.car_floor_now,
                           exp_st.mode_now, rsp_bus.car_mode_now,
                           exp_st.dir_now, rsp_bus.direction_now,
                           exp_st.target, rsp_bus.chosen_floor);
                  $display("  served %0d/%0d map %h/%h count %0d/%0d",
                           exp_st.served, rsp_bus.served,
                           exp_st.pend_map, rsp_bus.pending_map,
                           exp_st.pend_count, rsp_bus.pending_count);
               end
            end
         end
      end
   end

   // Reset, directed table, random items, drain, verdict
   initial begin
      car_status_type none;
      op_type         op;
      logic [REQ_FLOOR_W-1:0] rf;
      int             pick;
      int             n;
      none = '{default: '0};
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.operation     <= OP_STEP;
      req_bus.request_floor <= '0;
      pend_floors = '0;
      at_floor    = 1;
      heading     = DIR_STILL;
      car_state   = MODE_IDLE;
      mismatch_count = 0;
      error_count    = 0;
      rsp_count      = 0;

      // Directed: typed rows read straight off the behaviour, the rest from the predictor
      // tick with no work, out-of-range floors, both end floors
      directed_plan.push_back('{OP_STEP, 5'd0, 1'b1,
                                '{5'd1, MODE_IDLE, DIR_STILL, 5'd0, 1'b0, 16'h0000, 5'd0}});
      directed_plan.push_back('{OP_REQUEST, 5'd0, 1'b1,
                                '{5'd1, MODE_IDLE, DIR_STILL, 5'd0, 1'b0, 16'h0000, 5'd0}});
      directed_plan.push_back('{OP_REQUEST, 5'd17, 1'b1,
                                '{5'd1, MODE_IDLE, DIR_STILL, 5'd0, 1'b0, 16'h0000, 5'd0}});
      directed_plan.push_back('{OP_REQUEST, 5'd31, 1'b1,
                                '{5'd1, MODE_IDLE, DIR_STILL, 5'd0, 1'b0, 16'h0000, 5'd0}});
      directed_plan.push_back('{OP_REQUEST, 5'd16, 1'b1,
                                '{5'd1, MODE_IDLE, DIR_STILL, 5'd0, 1'b0, 16'h8000, 5'd1}});
      directed_plan.push_back('{OP_REQUEST, 5'd1, 1'b1,
                                '{5'd1, MODE_IDLE, DIR_STILL, 5'd0, 1'b0, 16'h8001, 5'd2}});
      // serve the current floor with no heading
      directed_plan.push_back('{OP_STEP, 5'd0, 1'b1,
                                '{5'd1, MODE_IDLE, DIR_STILL, 5'd1, 1'b1, 16'h8000, 5'd1}});
      // emergency: ticks, maintenance events ignored
      directed_plan.push_back('{OP_EMERG_SET, 5'd0, 1'b1,
                                '{5'd1, MODE_EMERG, DIR_STILL, 5'd0, 1'b0, 16'h8000, 5'd1}});
      directed_plan.push_back('{OP_STEP, 5'd0, 1'b1,
                                '{5'd1, MODE_EMERG, DIR_STILL, 5'd0, 1'b0, 16'h8000, 5'd1}});
      directed_plan.push_back('{OP_MAINT_ENTER, 5'd0, 1'b1,
                                '{5'd1, MODE_EMERG, DIR_STILL, 5'd0, 1'b0, 16'h8000, 5'd1}});
      directed_plan.push_back('{OP_MAINT_LEAVE, 5'd0, 1'b1,
                                '{5'd1, MODE_EMERG, DIR_STILL, 5'd0, 1'b0, 16'h8000, 5'd1}});
      // request stored while halted
      directed_plan.push_back('{OP_REQUEST, 5'd8, 1'b0, none});
      directed_plan.push_back('{OP_EMERG_CLEAR, 5'd0, 1'b1,
                                '{5'd1, MODE_IDLE, DIR_STILL, 5'd0, 1'b0, 16'h8080, 5'd2}});
      directed_plan.push_back('{OP_EMERG_CLEAR, 5'd0, 1'b0, none});
      directed_plan.push_back('{OP_MAINT_ENTER, 5'd0, 1'b0, none});
      directed_plan.push_back('{OP_STEP, 5'd0, 1'b0, none});
      directed_plan.push_back('{OP_EMERG_SET, 5'd0, 1'b0, none});
      directed_plan.push_back('{OP_EMERG_CLEAR, 5'd0, 1'b0, none});
      directed_plan.push_back('{OP_MAINT_ENTER, 5'd0, 1'b0, none});
      directed_plan.push_back('{OP_MAINT_LEAVE, 5'd0, 1'b0, none});
      directed_plan.push_back('{OP_SPARE6, 5'd31, 1'b0, none});
      directed_plan.push_back('{OP_SPARE7, 5'd0, 1'b0, none});
      // moves, then a request left behind the car
      directed_plan.push_back('{OP_STEP, 5'd0, 1'b0, none});
      directed_plan.push_back('{OP_REQUEST, 5'd1, 1'b0, none});
      directed_plan.push_back('{OP_STEP, 5'd0, 1'b0, none});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (reset);

      n = 0;
      foreach (directed_plan[i]) begin
         send_item(directed_plan[i].op, directed_plan[i].floor, n,
                   directed_plan[i].typed, directed_plan[i].want);
         n++;
      end

      // Random: mostly requests and ticks, halts that are left again fairly soon
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         pick = $urandom_range(0, 99);
         if ((car_state == MODE_EMERG || car_state == MODE_MAINT) && pick < 25)
            op = (car_state == MODE_EMERG) ? OP_EMERG_CLEAR : OP_MAINT_LEAVE;
         else if (pick < 50) op = OP_STEP;
         else if (pick < 86) op = OP_REQUEST;
         else if (pick < 89) op = OP_EMERG_SET;
         else if (pick < 91) op = OP_EMERG_CLEAR;
         else if (pick < 94) op = OP_MAINT_ENTER;
         else if (pick < 96) op = OP_MAINT_LEAVE;
         else op = ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
         if (op == OP_REQUEST && $urandom_range(0, 9) != 0)
            rf = REQ_FLOOR_W'($urandom_range(1, FLOORS));
         else
            rf = REQ_FLOOR_W'($urandom_range(0, 31));
         send_item(op, rf, n, 1'b0, none);
         n++;
      end
      req_bus.valid <= 1'b0;

      // Drain, then watch for stray results
      while (status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (status_q.size() != 0) error_count++;

      if (mismatch_count == 0 && error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
